FILE: src/i2cseq_pkg.sv
// ----------------------------------------------------------------------------
// i2cseq_pkg
// shared constants, types and helpers of the i2c command sequencer
// ----------------------------------------------------------------------------
package i2cseq_pkg;

  // queue geometry
  localparam int CMD_DEPTH = 32;
  localparam int CMD_AW    = $clog2(CMD_DEPTH);
  localparam int RX_DEPTH  = 16;
  localparam int RX_AW     = $clog2(RX_DEPTH);

  // request opcodes on the input channel
  localparam logic [1:0] REQ_PUSH   = 2'd0;
  localparam logic [1:0] REQ_LAUNCH = 2'd1;
  localparam logic [1:0] REQ_EVENT  = 2'd2;
  localparam logic [1:0] REQ_RX_POP = 2'd3;

  // command bytes
  localparam logic [7:0] CB_STOP    = 8'h04;
  localparam logic [7:0] CB_RESTART = 8'h10;
  localparam logic [7:0] CB_ADDR    = 8'h20;
  localparam logic [7:0] CB_SEND    = 8'h40;
  localparam logic [7:0] CB_RD_ACK  = 8'h80;
  localparam logic [7:0] CB_RD_NACK = 8'h81;

  // bus status codes, divided by eight
  localparam logic [4:0] ST_START     = 5'h01;  // 0x08
  localparam logic [4:0] ST_RESTART   = 5'h02;  // 0x10
  localparam logic [4:0] ST_SLAW_ACK  = 5'h03;  // 0x18
  localparam logic [4:0] ST_SLAW_NACK = 5'h04;  // 0x20
  localparam logic [4:0] ST_TXD_ACK   = 5'h05;  // 0x28
  localparam logic [4:0] ST_TXD_NACK  = 5'h06;  // 0x30
  localparam logic [4:0] ST_SLAR_ACK  = 5'h08;  // 0x40
  localparam logic [4:0] ST_SLAR_NACK = 5'h09;  // 0x48
  localparam logic [4:0] ST_RXD_ACK   = 5'h0A;  // 0x50
  localparam logic [4:0] ST_RXD_NACK  = 5'h0B;  // 0x58

  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_START      = 3'd1,
    ACT_STOP       = 3'd2,
    ACT_STOP_START = 3'd3,
    ACT_TX         = 3'd4,
    ACT_RX_ACK     = 3'd5,
    ACT_RX_NACK    = 3'd6
  } action_e;

  // controller to datapath strobes
  typedef struct packed {
    logic    accept;
    logic    cq_push;
    logic    push_stop;
    logic    cq_rd;
    logic    cq_adv;
    logic    cq_restore;
    logic    set_busy;
    logic    clr_busy;
    logic    report_ld;
    logic    task_inc;
    logic    rx_push;
    logic    rx_rd;
    logic    act_ld;
    action_e act;
    logic    tx_ld;
    logic    rxb_ld;
    logic    skip_inc;
    logic    out_load;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic busy;
    logic report;
    logic cq_empty;
    logic skip_last;
    logic out_busy;
    logic c_stop;
    logic c_restart;
    logic c_arg;
    logic c_rd_ack;
    logic c_rd_nack;
  } dp_sts_t;

  function automatic logic [CMD_AW-1:0] cq_wrap(input logic [CMD_AW-1:0] p);
    return (p == CMD_AW'(CMD_DEPTH - 1)) ? '0 : p + CMD_AW'(1);
  endfunction

  function automatic logic [RX_AW-1:0] rx_wrap(input logic [RX_AW-1:0] p);
    return (p == RX_AW'(RX_DEPTH - 1)) ? '0 : p + RX_AW'(1);
  endfunction

endpackage

FILE: src/i2cseq_ram.sv
// ----------------------------------------------------------------------------
// i2cseq_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module i2cseq_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/i2cseq_dp.sv
// ----------------------------------------------------------------------------
// i2cseq_dp
// queues, pointers, flags and result registers of the command sequencer
// ----------------------------------------------------------------------------
module i2cseq_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  i2cseq_pkg::dp_cmd_t  cmd_i,
  output i2cseq_pkg::dp_sts_t  sts_o,
  input  logic [7:0]           cmd_byte_i,
  input  logic [7:0]           rx_data_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic [2:0]           bus_action_o,
  output logic [7:0]           tx_byte_o,
  output logic [7:0]           rx_byte_o,
  output logic                 busy_res_o,
  output logic [7:0]           task_count_o,
  output logic                 cmd_overflow_o,
  output logic                 rx_overflow_o,
  output logic                 nack_flag_o
);

  localparam int CAW = i2cseq_pkg::CMD_AW;
  localparam int RAW = i2cseq_pkg::RX_AW;

  // latched request payload
  logic [7:0] byte_q;
  logic [7:0] rxd_q;

  // command queue
  logic [CAW-1:0]                    cq_rp_q, cq_wp_q, cq_here_q;
  logic [i2cseq_pkg::CMD_DEPTH-1:0]  cq_vld_q;
  logic                              cq_rd_vld_q;
  logic [7:0]                        cq_rdata, cq_wdata, cq_byte;
  logic [CAW-1:0]                    cq_wp_nxt;

  // receive queue
  logic [RAW-1:0]                    rx_rp_q, rx_wp_q;
  logic [i2cseq_pkg::RX_DEPTH-1:0]   rx_vld_q;
  logic                              rx_rd_vld_q;
  logic [7:0]                        rx_rdata;
  logic [RAW-1:0]                    rx_wp_nxt;

  logic                              busy_q, report_q;
  logic [7:0]                        tc_q;
  logic                              cq_ovf_q, rx_ovf_q, nack_q;
  logic [CAW-1:0]                    skip_q;

  i2cseq_pkg::action_e               act_q;
  logic [7:0]                        tx_q, rxb_q;

  logic                              out_valid_q;
  logic [2:0]                        out_act_q;
  logic [7:0]                        out_tx_q, out_rxb_q, out_tc_q;
  logic                              out_busy_q, out_cq_ovf_q, out_rx_ovf_q, out_nack_q;

  assign cq_wdata  = cmd_i.push_stop ? i2cseq_pkg::CB_STOP : byte_q;
  assign cq_wp_nxt = i2cseq_pkg::cq_wrap(cq_wp_q);
  assign rx_wp_nxt = i2cseq_pkg::rx_wrap(rx_wp_q);

  i2cseq_ram #(.Width(8), .Depth(i2cseq_pkg::CMD_DEPTH)) u_cmd_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.cq_push),
    .waddr_i (cq_wp_q),
    .wdata_i (cq_wdata),
    .re_i    (cmd_i.cq_rd),
    .raddr_i (cq_rp_q),
    .rdata_o (cq_rdata)
  );

  i2cseq_ram #(.Width(8), .Depth(i2cseq_pkg::RX_DEPTH)) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.rx_push),
    .waddr_i (rx_wp_q),
    .wdata_i (rxd_q),
    .re_i    (cmd_i.rx_rd),
    .raddr_i (rx_rp_q),
    .rdata_o (rx_rdata)
  );

  // never-written slots read as zero
  assign cq_byte = cq_rd_vld_q ? cq_rdata : 8'h00;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q <= cmd_byte_i;
      rxd_q  <= rx_data_i;
    end
    if (cmd_i.cq_rd) begin
      cq_here_q <= cq_rp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cq_rp_q     <= '0;
      cq_wp_q     <= '0;
      cq_vld_q    <= '0;
      cq_rd_vld_q <= 1'b0;
      rx_rp_q     <= '0;
      rx_wp_q     <= '0;
      rx_vld_q    <= '0;
      rx_rd_vld_q <= 1'b0;
      busy_q      <= 1'b0;
      report_q    <= 1'b0;
      tc_q        <= '0;
      cq_ovf_q    <= 1'b0;
      rx_ovf_q    <= 1'b0;
      nack_q      <= 1'b0;
      skip_q      <= '0;
      act_q       <= i2cseq_pkg::ACT_NONE;
      tx_q        <= '0;
      rxb_q       <= '0;
    end else begin
      if (cmd_i.cq_push) begin
        cq_vld_q[cq_wp_q] <= 1'b1;
        cq_wp_q           <= cq_wp_nxt;
        if (cq_wp_nxt == cq_rp_q) begin
          cq_ovf_q <= 1'b1;
        end
      end
      if (cmd_i.cq_rd) begin
        cq_rd_vld_q <= cq_vld_q[cq_rp_q];
      end
      if (cmd_i.cq_restore) begin
        cq_rp_q <= cq_here_q;
      end else if (cmd_i.cq_rd || cmd_i.cq_adv) begin
        cq_rp_q <= i2cseq_pkg::cq_wrap(cq_rp_q);
      end
      if (cmd_i.rx_push) begin
        nack_q            <= 1'b1;
        rx_vld_q[rx_wp_q] <= 1'b1;
        rx_wp_q           <= rx_wp_nxt;
        if (rx_wp_nxt == rx_rp_q) begin
          rx_ovf_q <= 1'b1;
        end
      end
      if (cmd_i.rx_rd) begin
        rx_rd_vld_q <= rx_vld_q[rx_rp_q];
        rx_rp_q     <= i2cseq_pkg::rx_wrap(rx_rp_q);
      end
      if (cmd_i.set_busy) begin
        busy_q <= 1'b1;
      end else if (cmd_i.clr_busy) begin
        busy_q <= 1'b0;
      end
      if (cmd_i.report_ld) begin
        report_q <= (cq_byte != 8'h00);
      end
      if (cmd_i.task_inc) begin
        tc_q <= tc_q + 8'd1;
      end
      if (cmd_i.accept) begin
        skip_q <= '0;
        act_q  <= i2cseq_pkg::ACT_NONE;
        tx_q   <= '0;
        rxb_q  <= '0;
      end else begin
        if (cmd_i.skip_inc) begin
          skip_q <= skip_q + CAW'(1);
        end
        if (cmd_i.act_ld) begin
          act_q <= cmd_i.act;
        end
        if (cmd_i.tx_ld) begin
          tx_q <= cq_byte;
        end
        if (cmd_i.rxb_ld) begin
          rxb_q <= rx_rd_vld_q ? rx_rdata : 8'h00;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_act_q    <= act_q;
      out_tx_q     <= tx_q;
      out_rxb_q    <= rxb_q;
      out_busy_q   <= busy_q;
      out_tc_q     <= tc_q;
      out_cq_ovf_q <= cq_ovf_q;
      out_rx_ovf_q <= rx_ovf_q;
      out_nack_q   <= nack_q;
    end
  end

  always_comb begin
    sts_o           = '0;
    sts_o.busy      = busy_q;
    sts_o.report    = report_q;
    sts_o.cq_empty  = (cq_rp_q == cq_wp_q);
    sts_o.skip_last = (skip_q == CAW'(i2cseq_pkg::CMD_DEPTH - 1));
    sts_o.out_busy  = out_valid_q && out_stall_i;
    sts_o.c_stop    = (cq_byte == i2cseq_pkg::CB_STOP);
    sts_o.c_restart = (cq_byte == i2cseq_pkg::CB_RESTART);
    sts_o.c_arg     = (cq_byte inside {i2cseq_pkg::CB_ADDR, i2cseq_pkg::CB_SEND});
    sts_o.c_rd_ack  = (cq_byte == i2cseq_pkg::CB_RD_ACK);
    sts_o.c_rd_nack = (cq_byte == i2cseq_pkg::CB_RD_NACK);
  end

  assign out_valid_o    = out_valid_q;
  assign bus_action_o   = out_act_q;
  assign tx_byte_o      = out_tx_q;
  assign rx_byte_o      = out_rxb_q;
  assign busy_res_o     = out_busy_q;
  assign task_count_o   = out_tc_q;
  assign cmd_overflow_o = out_cq_ovf_q;
  assign rx_overflow_o  = out_rx_ovf_q;
  assign nack_flag_o    = out_nack_q;

  // sticky flags never drop
  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cq_ovf_q || rx_ovf_q || nack_q |=> cq_ovf_q || rx_ovf_q || nack_q)
    else $error("sticky flag dropped");

  // a task is only counted in a reported packet
  a_task_rep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.task_inc |-> report_q)
    else $error("task counted without report flag");

  // restore only lands on a position taken by an earlier read
  a_restore: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cq_restore |-> $past(cmd_i.cq_rd, 2) || $past(cmd_i.cq_rd))
    else $error("pointer restore without prior read");

endmodule

FILE: src/i2cseq_ctrl.sv
// ----------------------------------------------------------------------------
// i2cseq_ctrl
// state machine that sequences queue accesses for one request
// ----------------------------------------------------------------------------
module i2cseq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           cmd_i,
  input  logic [4:0]           bus_status_i,
  output i2cseq_pkg::dp_cmd_t  dp_cmd_o,
  input  i2cseq_pkg::dp_sts_t  sts_i
);

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_PUSH     = 14'b00000000000010,
    S_CTRL_RD  = 14'b00000000000100,
    S_CTRL_CHK = 14'b00000000001000,
    S_RXPUSH   = 14'b00000000010000,
    S_SKIP_RD  = 14'b00000000100000,
    S_SKIP_CHK = 14'b00000001000000,
    S_RUN_RD   = 14'b00000010000000,
    S_RUN_CHK  = 14'b00000100000000,
    S_TX_RD    = 14'b00001000000000,
    S_TX_CHK   = 14'b00010000000000,
    S_RXP_RD   = 14'b00100000000000,
    S_RXP_CHK  = 14'b01000000000000,
    S_DONE     = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic   launch_q, launch_d;
  logic   accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    launch_d = launch_q;
    dp_cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          dp_cmd_o.accept = 1'b1;
          launch_d        = (cmd_i == i2cseq_pkg::REQ_LAUNCH);
          case (cmd_i)
            i2cseq_pkg::REQ_PUSH, i2cseq_pkg::REQ_LAUNCH: state_d = S_PUSH;
            i2cseq_pkg::REQ_EVENT: begin
              if (bus_status_i inside {i2cseq_pkg::ST_START, i2cseq_pkg::ST_RESTART,
                                       i2cseq_pkg::ST_SLAW_ACK, i2cseq_pkg::ST_TXD_ACK,
                                       i2cseq_pkg::ST_SLAR_ACK}) begin
                state_d = S_RUN_RD;
              end else if (bus_status_i inside {i2cseq_pkg::ST_RXD_ACK,
                                                i2cseq_pkg::ST_RXD_NACK}) begin
                state_d = S_RXPUSH;
              end else if (bus_status_i inside {i2cseq_pkg::ST_SLAW_NACK,
                                                i2cseq_pkg::ST_TXD_NACK,
                                                i2cseq_pkg::ST_SLAR_NACK}) begin
                state_d = S_SKIP_RD;
              end else begin
                state_d = S_DONE;
              end
            end
            default: state_d = S_RXP_RD;
          endcase
        end
      end
      S_PUSH: begin
        dp_cmd_o.cq_push   = 1'b1;
        dp_cmd_o.push_stop = launch_q;
        if (launch_q && !sts_i.busy) begin
          dp_cmd_o.set_busy = 1'b1;
          dp_cmd_o.act_ld   = 1'b1;
          dp_cmd_o.act      = i2cseq_pkg::ACT_START;
          state_d           = S_CTRL_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_CTRL_RD: begin
        dp_cmd_o.cq_rd = 1'b1;
        state_d        = S_CTRL_CHK;
      end
      S_CTRL_CHK: begin
        dp_cmd_o.report_ld = 1'b1;
        state_d            = S_DONE;
      end
      S_RXPUSH: begin
        dp_cmd_o.rx_push = 1'b1;
        state_d          = S_RUN_RD;
      end
      S_SKIP_RD: begin
        dp_cmd_o.cq_rd = 1'b1;
        state_d        = S_SKIP_CHK;
      end
      S_SKIP_CHK: begin
        if (sts_i.c_stop || sts_i.c_restart) begin
          dp_cmd_o.cq_restore = 1'b1;
          state_d             = S_RUN_RD;
        end else begin
          // address or send carries a payload byte to step over
          dp_cmd_o.cq_adv = sts_i.c_arg;
          if (sts_i.skip_last) begin
            state_d = S_RUN_RD;
          end else begin
            dp_cmd_o.skip_inc = 1'b1;
            state_d           = S_SKIP_RD;
          end
        end
      end
      S_RUN_RD: begin
        dp_cmd_o.cq_rd = 1'b1;
        state_d        = S_RUN_CHK;
      end
      S_RUN_CHK: begin
        state_d         = S_DONE;
        dp_cmd_o.act_ld = 1'b1;
        dp_cmd_o.act    = i2cseq_pkg::ACT_NONE;
        if (sts_i.c_stop) begin
          dp_cmd_o.task_inc = sts_i.report;
          if (sts_i.cq_empty) begin
            dp_cmd_o.clr_busy = 1'b1;
            dp_cmd_o.act      = i2cseq_pkg::ACT_STOP;
          end else begin
            dp_cmd_o.act = i2cseq_pkg::ACT_STOP_START;
            state_d      = S_CTRL_RD;
          end
        end else if (sts_i.c_restart) begin
          dp_cmd_o.act = i2cseq_pkg::ACT_START;
        end else if (sts_i.c_arg) begin
          dp_cmd_o.act = i2cseq_pkg::ACT_TX;
          state_d      = S_TX_RD;
        end else if (sts_i.c_rd_ack) begin
          dp_cmd_o.act = i2cseq_pkg::ACT_RX_ACK;
        end else if (sts_i.c_rd_nack) begin
          dp_cmd_o.act = i2cseq_pkg::ACT_RX_NACK;
        end
      end
      S_TX_RD: begin
        dp_cmd_o.cq_rd = 1'b1;
        state_d        = S_TX_CHK;
      end
      S_TX_CHK: begin
        dp_cmd_o.tx_ld = 1'b1;
        state_d        = S_DONE;
      end
      S_RXP_RD: begin
        dp_cmd_o.rx_rd = 1'b1;
        state_d        = S_RXP_CHK;
      end
      S_RXP_CHK: begin
        dp_cmd_o.rxb_ld = 1'b1;
        state_d         = S_DONE;
      end
      S_DONE: begin
        if (!sts_i.out_busy) begin
          dp_cmd_o.out_load = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      launch_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      launch_q <= launch_d;
    end
  end

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE)
    else $error("request accepted but sequencer stayed idle");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd_o.out_load |-> !sts_i.out_busy)
    else $error("result loaded over a waiting result");

  a_skip_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SKIP_CHK && sts_i.skip_last |=> state_q == S_RUN_RD)
    else $error("skip walk ran past queue depth");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd_o.out_load |=> state_q == S_IDLE)
    else $error("result loaded outside end of request");

endmodule

FILE: src/i2c_master_command_sequencer_unit.sv
// ----------------------------------------------------------------------------
// i2c_master_command_sequencer_unit
// i2c master command queue: pushes, bus events and receive pops, one result each
// ----------------------------------------------------------------------------
// latency follows the states a request passes: a push writes the queue, a
//   receive pop reads the receive ram, a launch on an idle bus reads the
//   control byte, a bus event decodes commands, a nack skip walks the queue
// throughput: one request at a time, the next one taken the cycle after the
//   result loads; each command byte walked takes a ram read and a decode state
// a finished result waits in the output register while the next request runs
// reset: async active low; pointers, flags, counter and queue valid bits clear,
//   so unwritten queue slots read as zero
// ----------------------------------------------------------------------------
module i2c_master_command_sequencer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  // request channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] cmd_i,
  input  logic [7:0] cmd_byte_i,
  input  logic [4:0] bus_status_i,
  input  logic [7:0] rx_data_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] bus_action_o,
  output logic [7:0] tx_byte_o,
  output logic [7:0] rx_byte_o,
  output logic       busy_res_o,
  output logic [7:0] task_count_o,
  output logic       cmd_overflow_o,
  output logic       rx_overflow_o,
  output logic       nack_flag_o
);

  // strobes from the sequencer fsm and status back from the datapath
  i2cseq_pkg::dp_cmd_t dp_cmd;
  i2cseq_pkg::dp_sts_t dp_sts;

  // controller: decodes the request and bus status, walks the queues
  i2cseq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .bus_status_i (bus_status_i),
    .dp_cmd_o     (dp_cmd),
    .sts_i        (dp_sts)
  );

  // datapath: command and receive rams, pointers, sticky flags, result register
  i2cseq_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .sts_o          (dp_sts),
    .cmd_byte_i     (cmd_byte_i),
    .rx_data_i      (rx_data_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .bus_action_o   (bus_action_o),
    .tx_byte_o      (tx_byte_o),
    .rx_byte_o      (rx_byte_o),
    .busy_res_o     (busy_res_o),
    .task_count_o   (task_count_o),
    .cmd_overflow_o (cmd_overflow_o),
    .rx_overflow_o  (rx_overflow_o),
    .nack_flag_o    (nack_flag_o)
  );

endmodule

FILE: verif/tb_i2c_master_command_sequencer_unit.sv
// ----------------------------------------------------------------------------
// tb_i2c_master_command_sequencer_unit
// self-checking bench for the i2c command sequencer: a short table of
// directed requests, then random packet traffic, scored against typed-in
// responses or an in-bench model of the command and receive queues
// ----------------------------------------------------------------------------
module tb_i2c_master_command_sequencer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cseq_pkg::*;

  localparam int RANDOM_ITEMS    = 950;
  localparam int CALM_ITEMS      = 120;   // tail of the run with no idling at all
  localparam int WATCHDOG_CYCLES = 4000;  // cycles with no handshake on either side
  localparam int DRAIN_CYCLES    = 2 * CMD_DEPTH + 16;
  localparam int DIR_ROWS        = 27;

  // one request as it goes onto the input channel
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
    logic [4:0] status;
    logic [7:0] rxd;
  } seq_req_t;

  // one result as it leaves the block
  typedef struct packed {
    action_e    action;
    logic [7:0] tx;
    logic [7:0] rx;
    logic       busy;
    logic [7:0] tasks;
    logic       cmd_ovf;
    logic       rx_ovf;
    logic       nack;
  } bus_resp_t;

  // directed row: the response is typed in only where it is obvious
  typedef struct {
    seq_req_t  req;
    bit        typed;
    bus_resp_t want;
  } dir_row_t;

  // how a bus status code is handled
  typedef enum {SC_IGNORE, SC_RUN, SC_STORE, SC_SKIP} status_kind_e;

  localparam bus_resp_t NO_CHECK = '0;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [1:0] cmd_i;
  logic [7:0] cmd_byte_i;
  logic [4:0] bus_status_i;
  logic [7:0] rx_data_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [2:0] bus_action_o;
  logic [7:0] tx_byte_o;
  logic [7:0] rx_byte_o;
  logic       busy_res_o;
  logic [7:0] task_count_o;
  logic       cmd_overflow_o;
  logic       rx_overflow_o;
  logic       nack_flag_o;

  i2c_master_command_sequencer_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .cmd_byte_i     (cmd_byte_i),
    .bus_status_i   (bus_status_i),
    .rx_data_i      (rx_data_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .bus_action_o   (bus_action_o),
    .tx_byte_o      (tx_byte_o),
    .rx_byte_o      (rx_byte_o),
    .busy_res_o     (busy_res_o),
    .task_count_o   (task_count_o),
    .cmd_overflow_o (cmd_overflow_o),
    .rx_overflow_o  (rx_overflow_o),
    .nack_flag_o    (nack_flag_o)
  );

  // --------------------------------------------------------------------------
  // model state of the sequencer
  // --------------------------------------------------------------------------
  logic [7:0] cq_mem [CMD_DEPTH];
  int         cq_rd, cq_wr;
  logic [7:0] rq_mem [RX_DEPTH];
  int         rq_rd, rq_wr;
  logic       m_busy, m_report, m_cmd_ovf, m_rx_ovf, m_nack;
  logic [7:0] m_tasks;

  bus_resp_t awaited_responses [$];
  seq_req_t  plan_q [$];
  int        mismatches;
  int        idle_cycles;
  bit        calm_tail;

  // directed requests, walked in order right after reset
  dir_row_t directed_rows [DIR_ROWS] = '{
    // unused status codes do nothing, lowest and highest code
    '{'{REQ_EVENT, 8'h00, 5'h00, 8'h00}, 1'b1, '{ACT_NONE, 8'h00, 8'h00, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0}},
    '{'{REQ_EVENT, 8'hFF, 5'h1F, 8'hFF}, 1'b1, '{ACT_NONE, 8'h00, 8'h00, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0}},
    // first packet, reported: every command byte once, a stop value as payload
    '{'{REQ_PUSH, 8'h01, 5'h00, 8'h00}, 1'b0, NO_CHECK},
    '{'{REQ_PUSH, CB_ADDR, 5'h00, 8'h00}, 1'b0, NO_CHECK},
    '{'{REQ_PUSH, 8'hFF, 5'h00, 8'h00}, 1'b0, NO_CHECK},
    '{'{REQ_PUSH, CB_SEND, 5'h00, 8'h00}, 1'b0, NO_CHECK},
    '{'{REQ_PUSH, CB_STOP, 5'h00, 8'h00}, 1'b0, NO_CHECK},
    '{'{REQ_PUSH, CB_RESTART, 5'h00, 8'h00}, 1'b0, NO_CHECK},
    '{'{REQ_PUSH, CB_RD_ACK, 5'h00, 8'h00}, 1'b0, NO_CHECK},
    '{'{REQ_PUSH, CB_RD_NACK, 5'h00, 8'h00}, 1'b0, NO_CHECK},
    // launch on an idle bus
    '{'{REQ_LAUNCH, 8'h00, 5'h00, 8'h00}, 1'b1, '{ACT_START, 8'h00, 8'h00, 1'b1, 8'd0, 1'b0, 1'b0, 1'b0}},
    // second packet queued behind, unreported
    '{'{REQ_PUSH, 8'h00, 5'h00, 8'h00}, 1'b0, NO_CHECK},
    '{'{REQ_PUSH, CB_ADDR, 5'h00, 8'h00}, 1'b0, NO_CHECK},
    '{'{REQ_PUSH, 8'h7F, 5'h00, 8'h00}, 1'b0, NO_CHECK},
    '{'{REQ_PUSH, CB_RD_ACK, 5'h00, 8'h00}, 1'b0, NO_CHECK},
    // launch while busy only queues the stop
    '{'{REQ_LAUNCH, 8'h00, 5'h00, 8'h00}, 1'b1, '{ACT_NONE, 8'h00, 8'h00, 1'b1, 8'd0, 1'b0, 1'b0, 1'b0}},
    '{'{REQ_EVENT, 8'h00, ST_START, 8'h00}, 1'b1, '{ACT_TX, 8'hFF, 8'h00, 1'b1, 8'd0, 1'b0, 1'b0, 1'b0}},
    '{'{REQ_EVENT, 8'h00, ST_SLAW_ACK, 8'h00}, 1'b1, '{ACT_TX, 8'h04, 8'h00, 1'b1, 8'd0, 1'b0, 1'b0, 1'b0}},
    '{'{REQ_EVENT, 8'h00, ST_TXD_ACK, 8'h00}, 1'b1, '{ACT_START, 8'h00, 8'h00, 1'b1, 8'd0, 1'b0, 1'b0, 1'b0}},
    '{'{REQ_EVENT, 8'h00, ST_RESTART, 8'h00}, 1'b1, '{ACT_RX_ACK, 8'h00, 8'h00, 1'b1, 8'd0, 1'b0, 1'b0, 1'b0}},
    '{'{REQ_EVENT, 8'h00, ST_RXD_ACK, 8'hFF}, 1'b1, '{ACT_RX_NACK, 8'h00, 8'h00, 1'b1, 8'd0, 1'b0, 1'b0, 1'b1}},
    // stop with more queued: task counted, next control byte taken
    '{'{REQ_EVENT, 8'h00, ST_RXD_NACK, 8'h00}, 1'b1, '{ACT_STOP_START, 8'h00, 8'h00, 1'b1, 8'd1, 1'b0, 1'b0, 1'b1}},
    // nack skip steps over the address payload and lands on the stop
    '{'{REQ_EVENT, 8'h00, ST_SLAR_NACK, 8'h00}, 1'b1, '{ACT_STOP, 8'h00, 8'h00, 1'b0, 8'd1, 1'b0, 1'b0, 1'b1}},
    '{'{REQ_RX_POP, 8'h00, 5'h00, 8'h00}, 1'b1, '{ACT_NONE, 8'h00, 8'hFF, 1'b0, 8'd1, 1'b0, 1'b0, 1'b1}},
    '{'{REQ_RX_POP, 8'h00, 5'h00, 8'h00}, 1'b1, '{ACT_NONE, 8'h00, 8'h00, 1'b0, 8'd1, 1'b0, 1'b0, 1'b1}},
    // pop from an empty receive queue returns an unwritten slot
    '{'{REQ_RX_POP, 8'h00, 5'h00, 8'h00}, 1'b1, '{ACT_NONE, 8'h00, 8'h00, 1'b0, 8'd1, 1'b0, 1'b0, 1'b1}},
    // skip on an empty command queue walks around and wraps
    '{'{REQ_EVENT, 8'h00, ST_TXD_NACK, 8'h00}, 1'b0, NO_CHECK}
  };

  // --------------------------------------------------------------------------
  // model helpers
  // --------------------------------------------------------------------------
  function automatic status_kind_e status_kind(input logic [4:0] s);
    case (s)
      ST_START, ST_RESTART, ST_SLAW_ACK, ST_TXD_ACK, ST_SLAR_ACK: return SC_RUN;
      ST_RXD_ACK, ST_RXD_NACK:                                   return SC_STORE;
      ST_SLAW_NACK, ST_TXD_NACK, ST_SLAR_NACK:                   return SC_SKIP;
      default:                                                   return SC_IGNORE;
    endcase
  endfunction

  // write always lands, even when it catches the read side
  function automatic void cq_push(input logic [7:0] v);
    cq_mem[cq_wr] = v;
    cq_wr = (cq_wr + 1) % CMD_DEPTH;
    if (cq_wr == cq_rd) m_cmd_ovf = 1'b1;
  endfunction

  // read never checks for empty, stale slots come back
  function automatic logic [7:0] cq_pop();
    logic [7:0] v;
    v = cq_mem[cq_rd];
    cq_rd = (cq_rd + 1) % CMD_DEPTH;
    return v;
  endfunction

  function automatic void rq_push(input logic [7:0] v);
    rq_mem[rq_wr] = v;
    rq_wr = (rq_wr + 1) % RX_DEPTH;
    if (rq_wr == rq_rd) m_rx_ovf = 1'b1;
  endfunction

  function automatic logic [7:0] rq_pop();
    logic [7:0] v;
    v = rq_mem[rq_rd];
    rq_rd = (rq_rd + 1) % RX_DEPTH;
    return v;
  endfunction

  // pop one command byte and turn it into a bus action
  function automatic action_e run_next_command(output logic [7:0] tx);
    logic [7:0] c;
    c  = cq_pop();
    tx = 8'h00;
    case (c)
      CB_STOP: begin
        if (m_report) m_tasks = m_tasks + 8'd1;
        if (cq_rd == cq_wr) begin
          m_busy = 1'b0;
          return ACT_STOP;
        end
        // next packet follows directly: its control byte decides reporting
        m_report = (cq_pop() != 8'h00);
        return ACT_STOP_START;
      end
      CB_RESTART:       return ACT_START;
      CB_ADDR, CB_SEND: begin
        tx = cq_pop();
        return ACT_TX;
      end
      CB_RD_ACK:        return ACT_RX_ACK;
      CB_RD_NACK:       return ACT_RX_NACK;
      default:          return ACT_NONE;
    endcase
  endfunction

  // advance the model by one request and return what the block must answer
  function automatic bus_resp_t predict_bus_response(input seq_req_t r);
    bus_resp_t    res;
    logic [7:0]   tx;
    logic [7:0]   c;
    status_kind_e kind;
    int           here;
    bit           hit;
    res = '0;
    tx  = 8'h00;
    case (r.op)
      REQ_PUSH: cq_push(r.data);
      REQ_LAUNCH: begin
        cq_push(CB_STOP);
        if (!m_busy) begin
          m_busy     = 1'b1;
          res.action = ACT_START;
          m_report   = (cq_pop() != 8'h00);
        end
      end
      REQ_EVENT: begin
        kind = status_kind(r.status);
        if (kind == SC_STORE) begin
          m_nack = 1'b1;
          rq_push(r.rxd);
        end
        if (kind == SC_SKIP) begin
          // walk to the next stop or restart, bounded by the queue depth
          hit = 1'b0;
          for (int n = 0; n < CMD_DEPTH && !hit; n++) begin
            here = cq_rd;
            c    = cq_pop();
            if (c == CB_ADDR || c == CB_SEND) begin
              void'(cq_pop());
            end else if (c == CB_STOP || c == CB_RESTART) begin
              cq_rd = here;
              hit   = 1'b1;
            end
          end
        end
        if (kind != SC_IGNORE) res.action = run_next_command(tx);
      end
      default: res.rx = rq_pop();
    endcase
    res.tx      = tx;
    res.busy    = m_busy;
    res.tasks   = m_tasks;
    res.cmd_ovf = m_cmd_ovf;
    res.rx_ovf  = m_rx_ovf;
    res.nack    = m_nack;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic seq_req_t make_req(input logic [1:0] op, input logic [7:0] data,
                                        input logic [4:0] status);
    seq_req_t r;
    r.op     = op;
    r.data   = data;
    r.status = status;
    r.rxd    = 8'($urandom);
    return r;
  endfunction

  // sender idles for a burst now and then, never in the calm tail
  task automatic sender_gap();
    if (!calm_tail && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  // present one request, hold it until taken, then record the expected response
  task automatic issue_request(input seq_req_t r, input bit typed, input bus_resp_t want);
    bus_resp_t predicted;
    in_valid_i   <= 1'b1;
    cmd_i        <= r.op;
    cmd_byte_i   <= r.data;
    bus_status_i <= r.status;
    rx_data_i    <= r.rxd;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = predict_bus_response(r);
    awaited_responses.push_back(typed ? want : predicted);
  endtask

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%02h, actual 0x%02h", name, want, got);
      mismatches++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // result side: random stall bursts, then free stretches of random length
  // --------------------------------------------------------------------------
  initial begin : stall_gen
    forever begin
      if (!calm_tail && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      // occasionally a long stretch with no stall at all
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(40, 120)) @(posedge clk_i);
      else repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // --------------------------------------------------------------------------
  // response scoreboard and watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    bus_resp_t want;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("i2c_master_command_sequencer_unit verification failed");
        $finish;
      end
      if (out_valid_o && !out_stall_i) begin
        if (awaited_responses.size() == 0) begin
          $error("response with no request outstanding");
          mismatches++;
        end else begin
          want = awaited_responses.pop_front();
          check_field("bus_action",   8'(want.action),  8'(bus_action_o));
          check_field("tx_byte",      want.tx,          tx_byte_o);
          check_field("rx_byte",      want.rx,          rx_byte_o);
          check_field("busy_res",     8'(want.busy),    8'(busy_res_o));
          check_field("task_count",   want.tasks,       task_count_o);
          check_field("cmd_overflow", 8'(want.cmd_ovf), 8'(cmd_overflow_o));
          check_field("rx_overflow",  8'(want.rx_ovf),  8'(rx_overflow_o));
          check_field("nack_flag",    8'(want.nack),    8'(nack_flag_o));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    seq_req_t   r;
    int         roll;
    int         cq_fill;
    int         rx_fill;
    int         live;
    logic [7:0] v;
    logic [4:0] st;

    // model after reset: queues read as zero until written
    foreach (cq_mem[i]) cq_mem[i] = 8'h00;
    foreach (rq_mem[i]) rq_mem[i] = 8'h00;
    cq_rd       = 0;
    cq_wr       = 0;
    rq_rd       = 0;
    rq_wr       = 0;
    m_busy      = 1'b0;
    m_report    = 1'b0;
    m_tasks     = 8'd0;
    m_cmd_ovf   = 1'b0;
    m_rx_ovf    = 1'b0;
    m_nack      = 1'b0;
    mismatches  = 0;
    idle_cycles = 0;
    calm_tail   = 1'b0;
    live        = 0;

    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    cmd_i        <= REQ_PUSH;
    cmd_byte_i   <= 8'h00;
    bus_status_i <= 5'h00;
    rx_data_i    <= 8'h00;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (directed_rows[i]) begin
      sender_gap();
      issue_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    end

    // random part: mostly well-formed packets and matching bus events,
    // some noise, rare floods that force a skip with no boundary in reach
    while (live < RANDOM_ITEMS) begin
      calm_tail = (live >= RANDOM_ITEMS - CALM_ITEMS);
      if (plan_q.size() == 0) begin
        roll    = $urandom_range(0, 99);
        cq_fill = (cq_wr - cq_rd + CMD_DEPTH) % CMD_DEPTH;
        rx_fill = (rq_wr - rq_rd + RX_DEPTH) % RX_DEPTH;
        if ($urandom_range(0, 299) == 0) begin
          // overwrite the whole command queue with non-boundary bytes
          for (int i = 0; i < CMD_DEPTH; i++) begin
            do v = 8'($urandom); while (v == CB_STOP || v == CB_RESTART);
            plan_q.push_back(make_req(REQ_PUSH, v, 5'($urandom)));
          end
          plan_q.push_back(make_req(REQ_EVENT, 8'($urandom), ST_TXD_NACK));
        end else if (roll < 8) begin
          plan_q.push_back(make_req(2'($urandom), 8'($urandom), 5'($urandom)));
        end else if (rx_fill != 0 && roll < 25) begin
          plan_q.push_back(make_req(REQ_RX_POP, 8'($urandom), 5'($urandom)));
        end else if (m_busy && (roll >= 33 || cq_fill >= 16)) begin
          // bus event while a transaction runs, a nack when the roll is below 42
          if (roll < 42) begin
            case ($urandom_range(0, 2))
              0:       st = ST_SLAW_NACK;
              1:       st = ST_TXD_NACK;
              default: st = ST_SLAR_NACK;
            endcase
          end else begin
            case ($urandom_range(0, 6))
              0:       st = ST_START;
              1:       st = ST_RESTART;
              2:       st = ST_SLAW_ACK;
              3:       st = ST_TXD_ACK;
              4:       st = ST_SLAR_ACK;
              5:       st = ST_RXD_ACK;
              default: st = ST_RXD_NACK;
            endcase
          end
          plan_q.push_back(make_req(REQ_EVENT, 8'($urandom), st));
        end else begin
          // new packet: control byte, one to four commands, stop
          v = $urandom_range(0, 1) ? 8'($urandom_range(1, 255)) : 8'h00;
          plan_q.push_back(make_req(REQ_PUSH, v, 5'($urandom)));
          repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 4))
              0: begin
                plan_q.push_back(make_req(REQ_PUSH, CB_ADDR, 5'($urandom)));
                plan_q.push_back(make_req(REQ_PUSH, 8'($urandom), 5'($urandom)));
              end
              1: begin
                plan_q.push_back(make_req(REQ_PUSH, CB_SEND, 5'($urandom)));
                plan_q.push_back(make_req(REQ_PUSH, 8'($urandom), 5'($urandom)));
              end
              2:       plan_q.push_back(make_req(REQ_PUSH, CB_RESTART, 5'($urandom)));
              3:       plan_q.push_back(make_req(REQ_PUSH, CB_RD_ACK, 5'($urandom)));
              default: plan_q.push_back(make_req(REQ_PUSH, CB_RD_NACK, 5'($urandom)));
            endcase
          end
          plan_q.push_back(make_req(REQ_LAUNCH, 8'($urandom), 5'($urandom)));
        end
      end
      r = plan_q.pop_front();
      // events with an unused status code do not count as traffic
      if (!(r.op == REQ_EVENT && status_kind(r.status) == SC_IGNORE)) live++;
      sender_gap();
      issue_request(r, 1'b0, NO_CHECK);
    end
    in_valid_i <= 1'b0;

    // drain, then let any late or stray response show up
    while (awaited_responses.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("i2c_master_command_sequencer_unit verification clean");
    end else begin
      $display("i2c_master_command_sequencer_unit verification failed");
    end
    $finish;
  end

endmodule
